// ===== rtl/pb2_pkg.sv =====
// shared constants, types and helpers of the 2x2 binning downscaler
`default_nettype none
package pb2_pkg;

   localparam int MAX_WIDTH  = 4096;
   localparam int MAX_HEIGHT = 4096;
   localparam int LINE_DEPTH = MAX_WIDTH / 2;

   localparam int SIZE_W = 13;
   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int ADDR_W = $clog2(LINE_DEPTH);

   localparam int LANES  = 4;
   localparam int CHAN_W = 8;
   localparam int PAIR_W = CHAN_W + 1;
   localparam int SUM_W  = CHAN_W + 2;
   localparam int LINE_W = LANES * PAIR_W;

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] REG_SOURCE_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_SOURCE_HEIGHT = 1'b1;

   localparam logic [SIZE_W-1:0] RESET_WIDTH  = SIZE_W'(1280);
   localparam logic [SIZE_W-1:0] RESET_HEIGHT = SIZE_W'(720);
   localparam logic [SIZE_W-1:0] MIN_SIZE     = SIZE_W'(2);

   typedef struct packed {
      logic hold_en;
      logic pair_load;
   } lane_ctrl_type;

   typedef logic [LANES-1:0][CHAN_W-1:0] lane_mean_type;

   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                    input logic [SIZE_W-1:0] maxv);
      logic [SIZE_W-1:0] r;
      if (v < MIN_SIZE) begin
         r = MIN_SIZE;
      end else if (v > maxv) begin
         r = maxv;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/pb2_line_buf.sv =====
// line buffer of horizontal pair sums, one write and one registered read port
`default_nettype none
module pb2_line_buf (
   input  wire logic                        clock,
   input  wire logic                        wr_en,
   input  wire logic [pb2_pkg::ADDR_W-1:0]  wr_addr,
   input  wire logic [pb2_pkg::LINE_W-1:0]  wr_data,
   input  wire logic                        rd_en,
   input  wire logic [pb2_pkg::ADDR_W-1:0]  rd_addr,
   output logic      [pb2_pkg::LINE_W-1:0]  rd_data
);

   logic [pb2_pkg::LINE_W-1:0] mem_ff [pb2_pkg::LINE_DEPTH];
   logic [pb2_pkg::LINE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== rtl/pb2_lane.sv =====
// one colour channel lane: pair sum, held pair and block mean
`default_nettype none
module pb2_lane (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire pb2_pkg::lane_ctrl_type       ctrl,
   input  wire logic [pb2_pkg::CHAN_W-1:0]   pix_in,
   input  wire logic [pb2_pkg::PAIR_W-1:0]   stored_pair,
   output logic      [pb2_pkg::PAIR_W-1:0]   pair_sum,
   output logic      [pb2_pkg::CHAN_W-1:0]   mean
);

   logic [pb2_pkg::CHAN_W-1:0] left_ff;
   logic [pb2_pkg::CHAN_W-1:0] left_in;
   logic [pb2_pkg::PAIR_W-1:0] pair_ff;
   logic [pb2_pkg::PAIR_W-1:0] pair_in;
   logic [pb2_pkg::SUM_W-1:0]  total;

   assign pair_sum = {1'b0, left_ff} + {1'b0, pix_in};

   assign left_in = ctrl.hold_en   ? pix_in   : left_ff;
   assign pair_in = ctrl.pair_load ? pair_sum : pair_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
      end else begin
         left_ff <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      pair_ff <= pair_in;
   end

   // four-value sum, truncated mean
   assign total = {1'b0, stored_pair} + {1'b0, pair_ff};
   assign mean  = total[pb2_pkg::SUM_W-1:2];

endmodule
`default_nettype wire

// ===== rtl/pb2_out_stage.sv =====
// output register that merges the lane means into one result transfer
`default_nettype none
module pb2_out_stage (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    blk_valid,
   input  wire pb2_pkg::lane_mean_type  blk_mean,
   input  wire logic                    blk_frame_end,
   output logic                         out_free,
   input  wire logic                    rsp_ready,
   output logic                         rsp_valid,
   output logic [pb2_pkg::CHAN_W-1:0]   rsp_blue_out,
   output logic [pb2_pkg::CHAN_W-1:0]   rsp_green_out,
   output logic [pb2_pkg::CHAN_W-1:0]   rsp_red_out,
   output logic [pb2_pkg::CHAN_W-1:0]   rsp_alpha_out,
   output logic                         rsp_frame_end
);

   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   pb2_pkg::lane_mean_type mean_ff;
   pb2_pkg::lane_mean_type mean_in;
   logic                   frame_end_ff;
   logic                   frame_end_in;
   logic                   load;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign load     = blk_valid && out_free;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign mean_in      = load ? blk_mean      : mean_ff;
   assign frame_end_in = load ? blk_frame_end : frame_end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mean_ff      <= mean_in;
      frame_end_ff <= frame_end_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_blue_out  = mean_ff[0];
   assign rsp_green_out = mean_ff[1];
   assign rsp_red_out   = mean_ff[2];
   assign rsp_alpha_out = mean_ff[3];
   assign rsp_frame_end = frame_end_ff;

endmodule
`default_nettype wire

// ===== rtl/pixel_binning_2x2_downscale.sv =====
// top level of the 2x2 pixel binning downscaler
//
// req channel: one BGRA32 source pixel per transfer, raster order. rsp channel:
// one downscaled pixel per 2x2 block, the per-channel sum of four shifted right
// by two, with frame_end on the last block of the frame. csr port: register 0
// is the source width, register 1 the source height; the user must write them
// only while idle, which the block itself does not enforce. Sizes below 2 act
// as 2, sizes above 4096 act as 4096. An odd last column or row is dropped.
// throughput: one pixel per clock while req_ready is high. The pixel that
// closes a block is held in the block stage while the line buffer read lands,
// then in the output register, before it appears on rsp.
// reset clears the counters, the left-pixel holds, the block stage valid and
// the output valid, and sets 1280 x 720. The line buffer needs no clearing:
// each entry is written on an even row before the odd row reads it.
// when the receiver stalls, a finished pixel waits in the output register and
// a second one in the block stage; pixels that close no block keep flowing,
// and req_ready drops only for a block-closing pixel with both stages full.
`default_nettype none
module pixel_binning_2x2_downscale (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [pb2_pkg::CHAN_W-1:0]      req_blue_in,
   input  wire logic [pb2_pkg::CHAN_W-1:0]      req_green_in,
   input  wire logic [pb2_pkg::CHAN_W-1:0]      req_red_in,
   input  wire logic [pb2_pkg::CHAN_W-1:0]      req_alpha_in,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [pb2_pkg::CHAN_W-1:0]           rsp_blue_out,
   output logic [pb2_pkg::CHAN_W-1:0]           rsp_green_out,
   output logic [pb2_pkg::CHAN_W-1:0]           rsp_red_out,
   output logic [pb2_pkg::CHAN_W-1:0]           rsp_alpha_out,
   output logic                                 rsp_frame_end,
   input  wire logic                            csr_we,
   input  wire logic [pb2_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [pb2_pkg::SIZE_W-1:0]      csr_wdata
);

   logic [pb2_pkg::SIZE_W-1:0] width_ff;
   logic [pb2_pkg::SIZE_W-1:0] width_in;
   logic [pb2_pkg::SIZE_W-1:0] height_ff;
   logic [pb2_pkg::SIZE_W-1:0] height_in;
   logic [pb2_pkg::COL_W-1:0]  col_ff;
   logic [pb2_pkg::COL_W-1:0]  col_in;
   logic [pb2_pkg::ROW_W-1:0]  row_ff;
   logic [pb2_pkg::ROW_W-1:0]  row_in;
   logic                       blk_valid_ff;
   logic                       blk_valid_in;
   logic                       blk_frame_end_ff;
   logic                       blk_frame_end_in;

   logic [pb2_pkg::SIZE_W-1:0] used_w;
   logic [pb2_pkg::SIZE_W-1:0] used_h;
   logic [pb2_pkg::SIZE_W-1:0] col_next;
   logic [pb2_pkg::SIZE_W-1:0] row_next;
   logic                       in_area;
   logic                       closes_block;
   logic                       frame_end_now;
   logic                       accept;
   logic                       out_free;
   logic                       wr_en;
   logic                       rd_en;
   logic [pb2_pkg::ADDR_W-1:0] slot;
   logic [pb2_pkg::LINE_W-1:0] wr_data;
   logic [pb2_pkg::LINE_W-1:0] rd_data;

   pb2_pkg::lane_ctrl_type     lane_ctrl;
   pb2_pkg::lane_mean_type     lane_mean;
   logic [pb2_pkg::LANES-1:0][pb2_pkg::CHAN_W-1:0] lane_pix;

   // configuration, kept already clamped
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         case (csr_index)
            pb2_pkg::REG_SOURCE_WIDTH: begin
               width_in = pb2_pkg::clamp_size(csr_wdata, pb2_pkg::SIZE_W'(pb2_pkg::MAX_WIDTH));
            end
            pb2_pkg::REG_SOURCE_HEIGHT: begin
               height_in = pb2_pkg::clamp_size(csr_wdata,
                                               pb2_pkg::SIZE_W'(pb2_pkg::MAX_HEIGHT));
            end
            default: begin
               width_in  = width_ff;
               height_in = height_ff;
            end
         endcase
      end
   end

   assign used_w = {width_ff[pb2_pkg::SIZE_W-1:1], 1'b0};
   assign used_h = {height_ff[pb2_pkg::SIZE_W-1:1], 1'b0};

   assign in_area = (pb2_pkg::SIZE_W'(col_ff) < used_w) && (pb2_pkg::SIZE_W'(row_ff) < used_h);
   assign closes_block  = in_area && col_ff[0] && row_ff[0];
   assign frame_end_now = (pb2_pkg::SIZE_W'(row_ff) == used_h - 1'b1) &&
                          (pb2_pkg::SIZE_W'(col_ff) == used_w - 1'b1);

   assign req_ready = !closes_block || !blk_valid_ff || out_free;
   assign accept    = req_valid && req_ready;

   // raster counters
   assign col_next = pb2_pkg::SIZE_W'(col_ff) + 1'b1;
   assign row_next = pb2_pkg::SIZE_W'(row_ff) + 1'b1;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_next >= width_ff) begin
            col_in = '0;
            if (row_next >= height_ff) begin
               row_in = '0;
            end else begin
               row_in = row_next[pb2_pkg::ROW_W-1:0];
            end
         end else begin
            col_in = col_next[pb2_pkg::COL_W-1:0];
         end
      end
   end

   // block stage: holds the pixel that closed a block while the line read lands
   always_comb begin
      blk_valid_in     = blk_valid_ff;
      blk_frame_end_in = blk_frame_end_ff;
      if (accept && closes_block) begin
         blk_valid_in     = 1'b1;
         blk_frame_end_in = frame_end_now;
      end else if (out_free) begin
         blk_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= pb2_pkg::RESET_WIDTH;
         height_ff    <= pb2_pkg::RESET_HEIGHT;
         col_ff       <= '0;
         row_ff       <= '0;
         blk_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         blk_valid_ff <= blk_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      blk_frame_end_ff <= blk_frame_end_in;
   end

   assign lane_ctrl.hold_en   = accept && in_area && !col_ff[0];
   assign lane_ctrl.pair_load = accept && closes_block;

   assign wr_en = accept && in_area && col_ff[0] && !row_ff[0];
   assign rd_en = accept && closes_block;
   assign slot  = col_ff[pb2_pkg::COL_W-1:1];

   assign lane_pix[0] = req_blue_in;
   assign lane_pix[1] = req_green_in;
   assign lane_pix[2] = req_red_in;
   assign lane_pix[3] = req_alpha_in;

   pb2_line_buf u_line_buf (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (slot),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (slot),
      .rd_data (rd_data)
   );

   for (genvar g = 0; g < pb2_pkg::LANES; g++) begin : g_lane
      pb2_lane u_lane (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (lane_ctrl),
         .pix_in      (lane_pix[g]),
         .stored_pair (rd_data[g*pb2_pkg::PAIR_W +: pb2_pkg::PAIR_W]),
         .pair_sum    (wr_data[g*pb2_pkg::PAIR_W +: pb2_pkg::PAIR_W]),
         .mean        (lane_mean[g])
      );
   end

   pb2_out_stage u_out_stage (
      .clock         (clock),
      .reset         (reset),
      .blk_valid     (blk_valid_ff),
      .blk_mean      (lane_mean),
      .blk_frame_end (blk_frame_end_ff),
      .out_free      (out_free),
      .rsp_ready     (rsp_ready),
      .rsp_valid     (rsp_valid),
      .rsp_blue_out  (rsp_blue_out),
      .rsp_green_out (rsp_green_out),
      .rsp_red_out   (rsp_red_out),
      .rsp_alpha_out (rsp_alpha_out),
      .rsp_frame_end (rsp_frame_end)
   );

   // a line entry is never written and read by the same transfer
   assert property (@(posedge clock) disable iff (reset) !(wr_en && rd_en))
      else $error("line buffer written and read by one transfer");

   // a held block is never dropped while the output is stalled
   assert property (@(posedge clock) disable iff (reset)
                    (blk_valid_ff && !out_free) |=> blk_valid_ff)
      else $error("block stage lost a pending pixel");

   // a block stage hand-over always shows up on rsp
   assert property (@(posedge clock) disable iff (reset)
                    (blk_valid_ff && out_free) |=> rsp_valid)
      else $error("block hand-over did not reach the output");

   // the frame end flag is only raised on a pixel in an odd row and column
   assert property (@(posedge clock) disable iff (reset)
                    (accept && closes_block && frame_end_now) |->
                    (col_ff[0] && row_ff[0]))
      else $error("frame end flagged off the last block");

endmodule
`default_nettype wire
